// ===== design/fr_pkg.sv =====
// shared types and constants for the fragment reassembler
`timescale 1ns / 1ps
`default_nettype none

package fr_pkg;

    // header sizes in bytes
    localparam int unsigned HDR_CONT  = 3;
    localparam int unsigned HDR_FIRST = 5;

    // frame position counter saturates here
    localparam int unsigned POS_W   = 10;
    localparam logic [POS_W-1:0] POS_MAX = 10'd1023;

    // frame length is position plus one
    localparam int unsigned LEN_W = POS_W + 1;

    // message counters, fixed by the 6-bit length field
    localparam int unsigned CNT_W = 6;

    // register indexes on the configuration port
    localparam logic REG_ENABLE = 1'b0;
    localparam logic REG_TYPE   = 1'b1;

    // frame status codes
    typedef enum logic [1:0] {
        ST_IGNORED  = 2'd0,
        ST_ACCEPTED = 2'd1,
        ST_COMPLETE = 2'd2,
        ST_ERROR    = 2'd3
    } fr_status_t;

    // result kinds
    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_DATA   = 1'b1;

    // control sequencer states
    typedef enum logic [2:0] {
        S_RUN  = 3'b001,
        S_READ = 3'b010,
        S_DATA = 3'b100
    } fr_state_t;

    // header and assembly context seen by the frame judge
    typedef struct packed {
        logic [LEN_W-1:0] frame_size;
        logic             cmd;
        logic             first;
        logic             last;
        logic             type_match;
        logic             overflow;
        logic [15:0]      total;
        logic [7:0]       sequence_no;
        logic             active;
        logic [7:0]       exp_sequence;
        logic [CNT_W-1:0] exp_total;
        logic [CNT_W-1:0] received;
    } fr_frame_t;

    // decision taken at frame end
    typedef struct packed {
        fr_status_t       status;
        logic             clear_asm;
        logic             load_first;
        logic             load_received;
        logic [CNT_W-1:0] received;
        logic [CNT_W-1:0] total;
    } fr_verdict_t;

endpackage

`default_nettype wire

// ===== design/fr_if.sv =====
// valid/ready channel interfaces for frame bytes and result items
`timescale 1ns / 1ps
`default_nettype none

interface fr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       frame_end;
    logic       write_command;

    modport source (output valid, frame_byte, frame_end, write_command, input ready);
    modport sink   (input valid, frame_byte, frame_end, write_command, output ready);
endinterface

interface fr_out_if;
    logic       valid;
    logic       ready;
    logic       result_kind;
    logic [1:0] frame_status;
    logic [7:0] message_byte;
    logic [5:0] message_length;
    logic       final_result;

    modport source (output valid, result_kind, frame_status, message_byte,
                    message_length, final_result, input ready);
    modport sink   (input valid, result_kind, frame_status, message_byte,
                    message_length, final_result, output ready);
endinterface

`default_nettype wire

// ===== design/fragment_reassembler_core.sv =====
// Fragment reassembler top level: header capture, payload store, status and readout.
// One frame byte is taken per cycle outside readout and, for a frame end, while the output
// register has room; payload bytes are written to the message ram as they come. A frame end
// loads one status item into the output register, valid the next cycle; a completed message
// then reads out its N bytes, each read from the ram, then loaded into the output register
// once free, with input held off for that burst. Reset (rst_n low, asynchronous) clears the
// assembly context, header registers and sequencer; ram contents stay undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module fragment_reassembler_core
    import fr_pkg::*;
#(
    parameter int unsigned BUFFER_SIZE = 32
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    fr_in_if.sink             frame_in,
    fr_out_if.source          result_out,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic      [31:0]  prdata,
    output logic              pready
);

    localparam int unsigned AW = (BUFFER_SIZE > 1) ? $clog2(BUFFER_SIZE) : 1;

    // configuration registers
    logic       enabled_reg;
    logic [7:0] acc_type_reg;

    // frame header and assembly context
    logic [POS_W-1:0] pos_reg,      pos_next;
    logic [7:0]       hdr_type_reg, hdr_type_cur;
    logic [1:0]       hdr_flags_reg, hdr_flags_cur;
    logic [7:0]       hdr_seq_reg,  hdr_seq_cur;
    logic [15:0]      hdr_total_reg, hdr_total_cur;
    logic             ovf_reg,      ovf_cur;
    logic             active_reg;
    logic [7:0]       exp_seq_reg;
    logic [CNT_W-1:0] exp_total_reg;
    logic [CNT_W-1:0] received_reg;

    // readout sequencer
    fr_state_t        state_reg, state_next;
    logic [CNT_W-1:0] rd_cnt_reg;
    logic [CNT_W-1:0] rd_total_reg;

    // output register
    logic             out_valid_reg;
    logic             out_kind_reg;
    logic [1:0]       out_status_reg;
    logic [7:0]       out_byte_reg;
    logic [5:0]       out_len_reg;
    logic             out_final_reg;

    logic             out_free;
    logic             in_accept;
    logic             end_accept;
    logic             data_load;
    logic             data_last;
    logic             type_match;
    logic [LEN_W-1:0] hdr_len;
    logic [LEN_W-1:0] store_idx;
    logic             in_payload;
    logic             ram_we;
    logic             ram_re;
    logic [7:0]       ram_rdata;
    logic             cfg_write;
    fr_frame_t        frame;
    fr_verdict_t      verdict;

    // apb register port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg  <= 1'b0;
            acc_type_reg <= 8'd0;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                REG_ENABLE: enabled_reg  <= pwdata[0];
                REG_TYPE:   acc_type_reg <= pwdata[7:0];
                default:    enabled_reg  <= enabled_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_ENABLE: prdata = {31'd0, enabled_reg};
            REG_TYPE:   prdata = {24'd0, acc_type_reg};
            default:    prdata = 32'd0;
        endcase
    end

    // input handshake: a frame end needs room in the output register
    assign out_free       = !out_valid_reg || result_out.ready;
    assign frame_in.ready = (state_reg == S_RUN) && (out_free || !frame_in.frame_end);
    assign in_accept      = frame_in.valid && frame_in.ready;
    assign end_accept     = in_accept && frame_in.frame_end;

    // header fields as they stand after this byte
    always_comb
    begin
        hdr_type_cur  = hdr_type_reg;
        hdr_flags_cur = hdr_flags_reg;
        hdr_seq_cur   = hdr_seq_reg;
        hdr_total_cur = hdr_total_reg;
        case (pos_reg)
            POS_W'(0): hdr_type_cur  = frame_in.frame_byte;
            POS_W'(1): hdr_flags_cur = frame_in.frame_byte[1:0];
            POS_W'(2): hdr_seq_cur   = frame_in.frame_byte;
            POS_W'(3): hdr_total_cur = {hdr_total_reg[15:8], frame_in.frame_byte};
            POS_W'(4): hdr_total_cur = {frame_in.frame_byte, hdr_total_reg[7:0]};
            default:   hdr_type_cur  = hdr_type_reg;
        endcase
    end

    // payload placement in the message ram
    assign type_match = (hdr_type_cur == acc_type_reg) && enabled_reg;
    assign hdr_len    = hdr_flags_cur[0] ? LEN_W'(HDR_FIRST) : LEN_W'(HDR_CONT);
    assign in_payload = (LEN_W'(pos_reg) >= hdr_len) && type_match;
    assign store_idx  = LEN_W'(pos_reg) - hdr_len +
                        (hdr_flags_cur[0] ? LEN_W'(0) : LEN_W'(received_reg));
    assign ram_we     = in_accept && in_payload && (store_idx < LEN_W'(BUFFER_SIZE));
    assign ovf_cur    = ovf_reg || (in_payload && (store_idx >= LEN_W'(BUFFER_SIZE)));

    // saturating frame position
    always_comb
    begin
        if (frame_in.frame_end)
        begin
            pos_next = '0;
        end
        else if (pos_reg == POS_MAX)
        begin
            pos_next = pos_reg;
        end
        else
        begin
            pos_next = pos_reg + POS_W'(1);
        end
    end

    // frame end evaluation
    always_comb
    begin
        frame.frame_size   = LEN_W'(pos_reg) + LEN_W'(1);
        frame.cmd          = frame_in.write_command;
        frame.first        = hdr_flags_cur[0];
        frame.last         = hdr_flags_cur[1];
        frame.type_match   = type_match;
        frame.overflow     = ovf_cur;
        frame.total        = hdr_total_cur;
        frame.sequence_no  = hdr_seq_cur;
        frame.active       = active_reg;
        frame.exp_sequence = exp_seq_reg;
        frame.exp_total    = exp_total_reg;
        frame.received     = received_reg;
    end

    fr_judge #(
        .BUFFER_SIZE (BUFFER_SIZE)
    ) u_judge (
        .frame   (frame),
        .verdict (verdict)
    );

    // header and assembly registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            hdr_type_reg  <= 8'd0;
            hdr_flags_reg <= 2'd0;
            hdr_seq_reg   <= 8'd0;
            hdr_total_reg <= 16'd0;
            ovf_reg       <= 1'b0;
            active_reg    <= 1'b0;
            exp_seq_reg   <= 8'd0;
            exp_total_reg <= '0;
            received_reg  <= '0;
        end
        else if (in_accept)
        begin
            pos_reg       <= pos_next;
            hdr_type_reg  <= hdr_type_cur;
            hdr_flags_reg <= hdr_flags_cur;
            hdr_seq_reg   <= hdr_seq_cur;
            hdr_total_reg <= hdr_total_cur;
            ovf_reg       <= frame_in.frame_end ? 1'b0 : ovf_cur;
            if (frame_in.frame_end)
            begin
                if (verdict.clear_asm)
                begin
                    active_reg    <= 1'b0;
                    exp_seq_reg   <= 8'd0;
                    exp_total_reg <= '0;
                    received_reg  <= '0;
                end
                else if (verdict.load_first)
                begin
                    active_reg    <= 1'b1;
                    exp_seq_reg   <= hdr_seq_cur;
                    exp_total_reg <= verdict.total;
                    received_reg  <= verdict.received;
                end
                else if (verdict.load_received)
                begin
                    received_reg  <= verdict.received;
                end
            end
        end
    end

    // readout sequencer
    assign ram_re    = (state_reg == S_READ);
    assign data_load = (state_reg == S_DATA) && out_free;
    assign data_last = (rd_cnt_reg + CNT_W'(1)) == rd_total_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_RUN:
            begin
                if (end_accept && verdict.status == ST_COMPLETE &&
                    verdict.total != '0)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:  state_next = S_DATA;
            S_DATA:
            begin
                if (out_free)
                begin
                    state_next = data_last ? S_RUN : S_READ;
                end
            end
            default: state_next = S_RUN;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_RUN;
            rd_cnt_reg   <= '0;
            rd_total_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (end_accept)
            begin
                rd_cnt_reg   <= '0;
                rd_total_reg <= verdict.total;
            end
            else if (data_load)
            begin
                rd_cnt_reg   <= rd_cnt_reg + CNT_W'(1);
            end
        end
    end

    // message store
    fr_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_SIZE)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (store_idx[AW-1:0]),
        .wdata (frame_in.frame_byte),
        .re    (ram_re),
        .raddr (rd_cnt_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    // output register: status item at frame end, data items during readout
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (end_accept || data_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (end_accept)
        begin
            out_kind_reg   <= KIND_STATUS;
            out_status_reg <= verdict.status;
            out_byte_reg   <= 8'd0;
            out_len_reg    <= (verdict.status == ST_COMPLETE) ? verdict.total : 6'd0;
            out_final_reg  <= (verdict.status != ST_COMPLETE) || (verdict.total == '0);
        end
        else if (data_load)
        begin
            out_kind_reg   <= KIND_DATA;
            out_status_reg <= ST_COMPLETE;
            out_byte_reg   <= ram_rdata;
            out_len_reg    <= rd_total_reg;
            out_final_reg  <= data_last;
        end
    end

    assign result_out.valid          = out_valid_reg;
    assign result_out.result_kind    = out_kind_reg;
    assign result_out.frame_status   = out_status_reg;
    assign result_out.message_byte   = out_byte_reg;
    assign result_out.message_length = out_len_reg;
    assign result_out.final_result   = out_final_reg;

    // no store write while a message is read out
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_RUN))
        else $error("message store written during readout");

    // readout index stays inside the completed message
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DATA) |-> (rd_cnt_reg < rd_total_reg))
        else $error("readout index past message length");

    // received count never exceeds the expected total
    assert property (@(posedge clk) disable iff (!rst_n)
        received_reg <= exp_total_reg)
        else $error("received count above expected total");

    // the last data item hands control back to frame intake
    assert property (@(posedge clk) disable iff (!rst_n)
        (data_load && data_last) |=> (state_reg == S_RUN))
        else $error("sequencer did not return after last data item");

endmodule

`default_nettype wire

// ===== design/fr_ram.sv =====
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module fr_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 32,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                  clk,
    input  wire logic                  we,
    input  wire logic [AW-1:0]         waddr,
    input  wire logic [WIDTH-1:0]      wdata,
    input  wire logic                  re,
    input  wire logic [AW-1:0]         raddr,
    output logic      [WIDTH-1:0]      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== design/fr_judge.sv =====
// frame-end evaluation: status and assembly update for one finished frame
`timescale 1ns / 1ps
`default_nettype none

module fr_judge
    import fr_pkg::*;
#(
    parameter int unsigned BUFFER_SIZE = 32
) (
    input  wire fr_frame_t   frame,
    output fr_verdict_t      verdict
);

    logic [LEN_W-1:0] frag_first;
    logic [LEN_W-1:0] frag_cont;
    logic [LEN_W:0]   cont_sum;

    // payload sizes for both header forms
    assign frag_first = frame.frame_size - LEN_W'(HDR_FIRST);
    assign frag_cont  = frame.frame_size - LEN_W'(HDR_CONT);
    assign cont_sum   = (LEN_W+1)'(frame.received) + (LEN_W+1)'(frag_cont);

    always_comb
    begin
        verdict               = '0;
        verdict.status        = ST_ERROR;
        verdict.clear_asm     = 1'b1;

        if (!frame.cmd || frame.frame_size < LEN_W'(HDR_CONT))
        begin
            verdict.status    = ST_ERROR;
        end
        else if (!frame.type_match)
        begin
            // foreign or unattended frame: leave assembly untouched
            verdict.status    = ST_IGNORED;
            verdict.clear_asm = 1'b0;
        end
        else if (frame.overflow)
        begin
            verdict.status    = ST_ERROR;
        end
        else if (frame.first)
        begin
            if (frame.frame_size < LEN_W'(HDR_FIRST))
            begin
                verdict.status = ST_ERROR;
            end
            else if (frame.total == 16'd0 || frame.total > 16'(BUFFER_SIZE) ||
                     16'(frag_first) > frame.total)
            begin
                verdict.status = ST_ERROR;
            end
            else if (frame.last)
            begin
                if (16'(frag_first) != frame.total)
                begin
                    verdict.status = ST_ERROR;
                end
                else
                begin
                    verdict.status = ST_COMPLETE;
                    verdict.total  = frame.total[CNT_W-1:0];
                end
            end
            else
            begin
                // opening fragment of a longer message
                verdict.status     = ST_ACCEPTED;
                verdict.clear_asm  = 1'b0;
                verdict.load_first = 1'b1;
                verdict.total      = frame.total[CNT_W-1:0];
                verdict.received   = frag_first[CNT_W-1:0];
            end
        end
        else if (!frame.active || frame.exp_sequence != frame.sequence_no)
        begin
            verdict.status = ST_ERROR;
        end
        else if (cont_sum > (LEN_W+1)'(frame.exp_total))
        begin
            verdict.status = ST_ERROR;
        end
        else if (frame.last)
        begin
            if (cont_sum != (LEN_W+1)'(frame.exp_total))
            begin
                verdict.status = ST_ERROR;
            end
            else
            begin
                verdict.status = ST_COMPLETE;
                verdict.total  = frame.exp_total;
            end
        end
        else
        begin
            // continuation that keeps the message open
            verdict.status        = ST_ACCEPTED;
            verdict.clear_asm     = 1'b0;
            verdict.load_received = 1'b1;
            verdict.received      = cont_sum[CNT_W-1:0];
        end
    end

endmodule

`default_nettype wire

// ===== bench/tb_fragment_reassembler_core.sv =====
// testbench for the fragment reassembler: frame streams, status and message readout checks
`timescale 1ns / 1ps

module tb_fragment_reassembler_core;
    import fr_pkg::*;

    localparam int BUF_SIZE = 32;

    // header flag bits
    localparam logic [7:0] FLAG_FIRST = 8'h01;
    localparam logic [7:0] FLAG_LAST  = 8'h02;

    // ways a random message gets damaged
    typedef enum int {
        DEFECT_NONE,
        DEFECT_SEQUENCE,
        DEFECT_NO_COMMAND,
        DEFECT_EXTRA_BYTE,
        DEFECT_MISSING_BYTE,
        DEFECT_FLAG_FLIP,
        DEFECT_BAD_HEADER
    } defect_t;

    typedef struct {
        logic       kind;
        fr_status_t status;
        logic [7:0] mbyte;
        logic [5:0] mlen;
        logic       is_last;
    } result_item_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    fr_in_if  frame_in ();
    fr_out_if result_out ();

    fragment_reassembler_core #(
        .BUFFER_SIZE (BUF_SIZE)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .frame_in   (frame_in),
        .result_out (result_out),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // predicted reassembler state
    logic [7:0]  msg_mem [BUF_SIZE];
    logic        asm_active;
    logic [7:0]  asm_seq;
    logic [5:0]  asm_total;
    logic [5:0]  asm_count;
    logic [9:0]  frame_pos;
    logic [7:0]  hdr_type;
    logic [1:0]  hdr_flags;
    logic [7:0]  hdr_seq;
    logic [15:0] hdr_total;
    logic        hdr_overflow;
    logic        rx_enable;
    logic [7:0]  rx_type;

    result_item_t expected_results [$];
    result_item_t seen_results [$];
    logic [7:0]   frame_buf [$];

    int err_count = 0;
    int sent_items;
    int send_idle_pct;
    int recv_stall_pct;

    // clock
    initial clk = 1'b0;
    always #1 clk = ~clk;

    // end the run if it hangs
    initial
    begin
        #400000;
        $display("tb_fragment_reassembler_core: done, errors");
        $finish;
    end

    // assembly context clear on error or completion
    function automatic void drop_assembly();
        asm_active = 1'b0;
        asm_seq    = '0;
        asm_total  = '0;
        asm_count  = '0;
    endfunction

    // frame end verdict from header and assembly context
    function automatic fr_status_t judge_frame_end(int flen, logic cmd);
        int frag;
        if (!cmd || flen < HDR_CONT)
        begin
            drop_assembly();
            return ST_ERROR;
        end
        if (hdr_type != rx_type || !rx_enable)
            return ST_IGNORED;
        if (hdr_overflow)
        begin
            drop_assembly();
            return ST_ERROR;
        end
        if (hdr_flags[0])
        begin
            if (flen < HDR_FIRST)
            begin
                drop_assembly();
                return ST_ERROR;
            end
            frag = flen - HDR_FIRST;
            if (hdr_total == 0 || hdr_total > BUF_SIZE || frag > hdr_total)
            begin
                drop_assembly();
                return ST_ERROR;
            end
            if (hdr_flags[1])
            begin
                if (frag != hdr_total)
                begin
                    drop_assembly();
                    return ST_ERROR;
                end
                asm_total = hdr_total[5:0];
                return ST_COMPLETE;
            end
            asm_active = 1'b1;
            asm_seq    = hdr_seq;
            asm_total  = hdr_total[5:0];
            asm_count  = frag[5:0];
            return ST_ACCEPTED;
        end
        if (!asm_active || asm_seq != hdr_seq)
        begin
            drop_assembly();
            return ST_ERROR;
        end
        frag = flen - HDR_CONT;
        if (int'(asm_count) + frag > int'(asm_total))
        begin
            drop_assembly();
            return ST_ERROR;
        end
        asm_count = asm_count + frag[5:0];
        if (hdr_flags[1])
        begin
            if (asm_count != asm_total)
            begin
                drop_assembly();
                return ST_ERROR;
            end
            return ST_COMPLETE;
        end
        return ST_ACCEPTED;
    endfunction

    // one accepted frame byte: header capture, store write, results at frame end
    function automatic void model_frame_byte(logic [7:0] b, logic fend, logic cmd);
        int p;
        int hdr;
        int idx;
        int tot;
        fr_status_t st;
        result_item_t r;
        p = frame_pos;
        case (p)
            0: hdr_type = b;
            1: hdr_flags = b[1:0];
            2: hdr_seq = b;
            3: hdr_total[7:0] = b;
            4: hdr_total[15:8] = b;
            default: ;
        endcase
        hdr = hdr_flags[0] ? HDR_FIRST : HDR_CONT;
        if (p >= hdr && hdr_type == rx_type && rx_enable)
        begin
            idx = p - hdr;
            if (!hdr_flags[0])
                idx += asm_count;
            if (idx < BUF_SIZE)
                msg_mem[idx] = b;
            else
                hdr_overflow = 1'b1;
        end
        if (frame_pos < POS_MAX)
            frame_pos = frame_pos + 1'b1;
        if (!fend)
            return;

        st = judge_frame_end(p + 1, cmd);
        frame_pos    = '0;
        hdr_overflow = 1'b0;
        if (st != ST_COMPLETE)
        begin
            r = '{KIND_STATUS, st, 8'h00, 6'd0, 1'b1};
            expected_results.push_back(r);
            return;
        end
        // completion status, then the message bytes
        tot = asm_total;
        r = '{KIND_STATUS, ST_COMPLETE, 8'h00, tot[5:0], tot == 0};
        expected_results.push_back(r);
        for (int i = 0; i < tot; i++)
        begin
            r = '{KIND_DATA, ST_COMPLETE, msg_mem[i], tot[5:0], i == tot - 1};
            expected_results.push_back(r);
        end
        drop_assembly();
    endfunction

    // send one frame byte with random idle cycles in front
    task automatic push_frame_byte(input logic [7:0] b, input logic fend, input logic cmd);
        while ($urandom_range(99) < send_idle_pct)
        begin
            frame_in.valid <= 1'b0;
            @(posedge clk);
        end
        frame_in.valid         <= 1'b1;
        frame_in.frame_byte    <= b;
        frame_in.frame_end     <= fend;
        frame_in.write_command <= cmd;
        @(posedge clk);
        while (!frame_in.ready)
            @(posedge clk);
        model_frame_byte(b, fend, cmd);
        sent_items++;
    endtask

    // send part of the frame buffer; command flag matters only on the final byte
    task automatic send_span(input int from, input int upto, input logic cmd);
        logic last_byte;
        for (int i = from; i < upto; i++)
        begin
            last_byte = (i == frame_buf.size() - 1);
            push_frame_byte(frame_buf[i], last_byte, last_byte ? cmd : 1'($urandom_range(1)));
        end
    endtask

    task automatic send_frame(input logic cmd);
        send_span(0, frame_buf.size(), cmd);
    endtask

    // header plus random payload into the frame buffer
    task automatic make_frame(input logic [7:0] typ, input logic [7:0] flags,
                              input logic [7:0] seq, input logic with_total,
                              input logic [15:0] total, input int payload_n);
        frame_buf = {};
        frame_buf.push_back(typ);
        frame_buf.push_back(flags);
        frame_buf.push_back(seq);
        if (with_total)
        begin
            frame_buf.push_back(total[7:0]);
            frame_buf.push_back(total[15:8]);
        end
        repeat (payload_n)
            frame_buf.push_back(8'($urandom));
    endtask

    task automatic trim_frame(input int n);
        while (frame_buf.size() > n)
            void'(frame_buf.pop_back());
    endtask

    // wait for every expected result, then let the block drain
    task automatic settle_block();
        frame_in.valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0 || seen_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    // register write: setup then access phase, block idle
    task automatic write_reg(input logic idx, input logic [31:0] value);
        settle_block();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_ENABLE)
            rx_enable = value[0];
        else
            rx_type = value[7:0];
    endtask

    // result sampling and receiver stalls
    always @(posedge clk)
    begin : result_capture
        result_item_t act;
        if (rst_n && result_out.valid && result_out.ready)
        begin
            act.kind    = result_out.result_kind;
            act.status  = fr_status_t'(result_out.frame_status);
            act.mbyte   = result_out.message_byte;
            act.mlen    = result_out.message_length;
            act.is_last = result_out.final_result;
            seen_results.push_back(act);
        end
        result_out.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic void report_field(string field, int expv, int actv);
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, expv, actv);
        err_count++;
    endfunction

    // compare after the sender has predicted the items of this edge
    always @(negedge clk)
    begin : result_compare
        result_item_t act;
        result_item_t exp_r;
        while (seen_results.size() != 0)
        begin
            act = seen_results.pop_front();
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none actual kind %0h status %0h",
                         $time, act.kind, act.status);
                err_count++;
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (act.kind !== exp_r.kind)
                    report_field("result_kind", exp_r.kind, act.kind);
                if (act.status !== exp_r.status)
                    report_field("frame_status", exp_r.status, act.status);
                if (act.mbyte !== exp_r.mbyte)
                    report_field("message_byte", exp_r.mbyte, act.mbyte);
                if (act.mlen !== exp_r.mlen)
                    report_field("message_length", exp_r.mlen, act.mlen);
                if (act.is_last !== exp_r.is_last)
                    report_field("final_result", exp_r.is_last, act.is_last);
            end
        end
    end

    // frames under reset settings: receiver off, type zero
    task automatic test_reset_defaults();
        make_frame(8'h00, FLAG_FIRST | FLAG_LAST, 8'h00, 1'b1, 16'd1, 1);
        send_frame(1'b1);
        make_frame(8'h00, FLAG_FIRST, 8'h00, 1'b0, 16'd0, 0);
        trim_frame(2);
        send_frame(1'b1);
    endtask

    // single-frame messages and first-fragment header errors
    task automatic test_single_frames();
        write_reg(REG_ENABLE, 32'd1);
        write_reg(REG_TYPE, 32'hA5);
        make_frame(8'hA5, FLAG_FIRST | FLAG_LAST, 8'h07, 1'b1, 16'd2, 2);
        frame_buf[5] = 8'hFF;
        frame_buf[6] = 8'h00;
        send_frame(1'b1);
        // wrong type
        make_frame(8'h5A, FLAG_FIRST | FLAG_LAST, 8'h00, 1'b1, 16'd1, 1);
        send_frame(1'b1);
        // not a write command
        make_frame(8'hA5, FLAG_FIRST | FLAG_LAST, 8'h00, 1'b1, 16'd1, 1);
        send_frame(1'b0);
        // first fragment cut inside the length field
        make_frame(8'hA5, FLAG_FIRST | FLAG_LAST, 8'h00, 1'b1, 16'd1, 0);
        trim_frame(4);
        send_frame(1'b1);
        // zero total, total past capacity, payload past total
        make_frame(8'hA5, FLAG_FIRST | FLAG_LAST, 8'h00, 1'b1, 16'd0, 0);
        send_frame(1'b1);
        make_frame(8'hA5, FLAG_FIRST, 8'h00, 1'b1, 16'hFFFF, 1);
        send_frame(1'b1);
        make_frame(8'hA5, FLAG_FIRST, 8'h00, 1'b1, 16'd2, 3);
        send_frame(1'b1);
        // single frame short of its total
        make_frame(8'hA5, FLAG_FIRST | FLAG_LAST, 8'h00, 1'b1, 16'd4, 3);
        send_frame(1'b1);
    endtask

    // multi-frame messages and continuation errors
    task automatic test_fragments();
        make_frame(8'hA5, FLAG_FIRST, 8'hFF, 1'b1, 16'd5, 2);
        send_frame(1'b1);
        make_frame(8'hA5, 8'h00, 8'hFF, 1'b0, 16'd0, 1);
        send_frame(1'b1);
        make_frame(8'hA5, FLAG_LAST, 8'hFF, 1'b0, 16'd0, 2);
        send_frame(1'b1);
        // sequence mismatch, then continuation with nothing active
        make_frame(8'hA5, FLAG_FIRST, 8'h03, 1'b1, 16'd4, 1);
        send_frame(1'b1);
        make_frame(8'hA5, FLAG_LAST, 8'h04, 1'b0, 16'd0, 3);
        send_frame(1'b1);
        make_frame(8'hA5, FLAG_LAST, 8'h03, 1'b0, 16'd0, 3);
        send_frame(1'b1);
        // continuation past the total
        make_frame(8'hA5, FLAG_FIRST, 8'h01, 1'b1, 16'd3, 2);
        send_frame(1'b1);
        make_frame(8'hA5, FLAG_LAST, 8'h01, 1'b0, 16'd0, 2);
        send_frame(1'b1);
        // last fragment short of the total
        make_frame(8'hA5, FLAG_FIRST, 8'h01, 1'b1, 16'd3, 1);
        send_frame(1'b1);
        make_frame(8'hA5, FLAG_LAST, 8'h01, 1'b0, 16'd0, 1);
        send_frame(1'b1);
    endtask

    // full buffer message and payload past capacity
    task automatic test_capacity();
        make_frame(8'hA5, FLAG_FIRST | FLAG_LAST, 8'h09, 1'b1, 16'd32, 32);
        send_frame(1'b1);
        make_frame(8'hA5, FLAG_FIRST, 8'h09, 1'b1, 16'd32, 30);
        send_frame(1'b1);
        make_frame(8'hA5, FLAG_LAST, 8'h09, 1'b0, 16'd0, 5);
        send_frame(1'b1);
    endtask

    // registers changed inside a frame; the verdict uses the values at frame end
    task automatic test_mid_frame_config();
        make_frame(8'hA5, FLAG_FIRST | FLAG_LAST, 8'h11, 1'b1, 16'd3, 3);
        send_span(0, 4, 1'b1);
        write_reg(REG_ENABLE, 32'd0);
        send_span(4, frame_buf.size(), 1'b1);
        write_reg(REG_ENABLE, 32'd1);
        // type switched after the header, before any payload
        make_frame(8'h3C, FLAG_FIRST | FLAG_LAST, 8'h12, 1'b1, 16'd3, 3);
        send_span(0, 5, 1'b1);
        write_reg(REG_TYPE, 32'h3C);
        send_span(5, frame_buf.size(), 1'b1);
    endtask

    // one random message, possibly damaged, or a noise frame
    task automatic send_random_message();
        int r;
        int total;
        int nfrag;
        int left;
        int part;
        int k;
        logic [7:0] typ;
        logic [7:0] seq;
        logic [7:0] flags;
        logic cmd;
        defect_t defect;
        if ($urandom_range(99) < 15)
        begin
            frame_buf = {};
            repeat ($urandom_range(1, 6))
                frame_buf.push_back(8'($urandom));
            send_frame(1'($urandom_range(1)));
            return;
        end
        r = $urandom_range(99);
        total = (r < 65) ? $urandom_range(1, 8) : (r < 90) ? $urandom_range(9, 31) : 32;
        nfrag = $urandom_range(1, 3);
        seq = 8'($urandom);
        typ = ($urandom_range(99) < 90) ? rx_type : 8'($urandom);
        defect = ($urandom_range(99) < 70) ? DEFECT_NONE : defect_t'($urandom_range(1, 6));
        k = $urandom_range(0, nfrag - 1);
        left = total;
        for (int i = 0; i < nfrag; i++)
        begin
            part = (i == nfrag - 1) ? left : $urandom_range(0, left);
            left -= part;
            flags = 8'($urandom) & ~(FLAG_FIRST | FLAG_LAST);
            if (i == 0)
                flags |= FLAG_FIRST;
            if (i == nfrag - 1)
                flags |= FLAG_LAST;
            make_frame(typ, flags, seq, i == 0, 16'(total), part);
            cmd = 1'b1;
            if (i == k)
            begin
                case (defect)
                    DEFECT_SEQUENCE: frame_buf[2] = seq + 8'd1;
                    DEFECT_NO_COMMAND: cmd = 1'b0;
                    DEFECT_EXTRA_BYTE: frame_buf.push_back(8'($urandom));
                    DEFECT_MISSING_BYTE: trim_frame(frame_buf.size() - 1);
                    DEFECT_FLAG_FLIP: frame_buf[1] = frame_buf[1] ^ FLAG_FIRST;
                    DEFECT_BAD_HEADER:
                        if (i == 0)
                            frame_buf[4] = 8'($urandom_range(1, 255));
                        else
                            trim_frame($urandom_range(1, 2));
                    default: ;
                endcase
            end
            send_frame(cmd);
        end
    endtask

    // random phases over idle patterns and register settings
    task automatic test_random_traffic();
        int send_tbl [4] = '{0, 82, 0, 9};
        int recv_tbl [4] = '{0, 0, 82, 9};
        int start_count;
        int target;
        logic [7:0] typ;
        for (int ph = 0; ph < 7; ph++)
        begin
            typ = (ph == 0) ? 8'h00 : (ph == 1) ? 8'hFF : 8'($urandom);
            write_reg(REG_ENABLE, (ph == 3) ? 32'd0 : 32'd1);
            write_reg(REG_TYPE, {24'd0, typ});
            send_idle_pct  = send_tbl[ph % 4];
            recv_stall_pct = recv_tbl[ph % 4];
            target = rx_enable ? 6 : 3;
            start_count = sent_items;
            while (sent_items - start_count < target)
                send_random_message();
        end
    endtask

    // stimulus sequence
    initial
    begin
        rst_n                  = 1'b0;
        psel                   = 1'b0;
        penable                = 1'b0;
        pwrite                 = 1'b0;
        paddr                  = '0;
        pwdata                 = '0;
        frame_in.valid         = 1'b0;
        frame_in.frame_byte    = '0;
        frame_in.frame_end     = 1'b0;
        frame_in.write_command = 1'b0;
        sent_items             = 0;
        send_idle_pct          = 9;
        recv_stall_pct         = 9;
        hdr_type               = '0;
        hdr_flags              = '0;
        hdr_seq                = '0;
        hdr_total              = '0;
        hdr_overflow           = 1'b0;
        frame_pos              = '0;
        rx_enable              = 1'b0;
        rx_type                = '0;
        drop_assembly();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_single_frames();
        test_fragments();
        test_capacity();
        test_mid_frame_config();
        test_random_traffic();
        settle_block();

        if (err_count == 0)
            $display("tb_fragment_reassembler_core: done, clean");
        else
            $display("tb_fragment_reassembler_core: done, errors");
        $finish;
    end

endmodule
